// ===== src/sppl_pkg.sv =====
// ---------------------------------------------------------------------------
// sppl_pkg
// shared types, constants and command codes of the ping-pong link checker
// ---------------------------------------------------------------------------
package sppl_pkg;

   localparam int LINE_CAPACITY = 16;
   localparam int TIMER_WIDTH   = 16;
   localparam int LL_W          = $clog2(LINE_CAPACITY);
   localparam int CFG_W         = 16;
   localparam int CMP_W         = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
   localparam int IDX_W         = 3;

   // request commands
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_TICK  = 2'd1;
   localparam logic [1:0] CMD_BYTE  = 2'd2;

   // check phases
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_WARMUP = 2'd1;
   localparam logic [1:0] PH_DRAIN  = 2'd2;
   localparam logic [1:0] PH_SERIES = 2'd3;

   // register indexes
   localparam logic [IDX_W-1:0] REG_EXCHANGE_COUNT = 3'd0;
   localparam logic [IDX_W-1:0] REG_REPLY_TIMEOUT  = 3'd1;
   localparam logic [IDX_W-1:0] REG_WARMUP         = 3'd2;
   localparam logic [IDX_W-1:0] REG_PROBE_WAIT     = 3'd3;
   localparam logic [IDX_W-1:0] REG_SILENCE        = 3'd4;

   // special characters
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_P   = 8'h50;
   localparam logic [7:0] CH_O   = 8'h4F;
   localparam logic [7:0] CH_N   = 8'h4E;
   localparam logic [7:0] CH_G   = 8'h47;

   // classified request
   typedef struct packed {
      logic [1:0] cmd;
      logic       is_lf;
      logic       is_cr;
      logic       is_nul;
      logic       is_letter;
      logic [1:0] letter;
   } cls_type;

   // one result
   typedef struct packed {
      logic       send_ping;
      logic       done_res;
      logic       passed;
      logic       warmup_failed;
      logic [7:0] pong_count;
      logic       busy_res;
   } rsp_type;

endpackage

// ===== src/sppl_front.sv =====
// ---------------------------------------------------------------------------
// sppl_front
// decodes a request and classifies its byte for the line matcher
// ---------------------------------------------------------------------------
module sppl_front (
   input  logic             push,
   input  logic             full,
   input  logic [1:0]       command,
   input  logic [7:0]       rx_byte,
   output logic             q_push,
   output sppl_pkg::cls_type q_data
);

   always_comb begin
      q_push           = push & ~full;
      q_data.cmd       = command;
      q_data.is_lf     = (rx_byte == sppl_pkg::CH_LF);
      q_data.is_cr     = (rx_byte == sppl_pkg::CH_CR);
      q_data.is_nul    = (rx_byte == sppl_pkg::CH_NUL);
      q_data.is_letter = 1'b1;
      q_data.letter    = 2'd0;
      case (rx_byte)
         sppl_pkg::CH_P: q_data.letter = 2'd0;
         sppl_pkg::CH_O: q_data.letter = 2'd1;
         sppl_pkg::CH_N: q_data.letter = 2'd2;
         sppl_pkg::CH_G: q_data.letter = 2'd3;
         default:        q_data.is_letter = 1'b0;
      endcase
   end

endmodule

// ===== src/sppl_cmd_fifo.sv =====
// ---------------------------------------------------------------------------
// sppl_cmd_fifo
// two-entry queue of classified requests between front and engine
// ---------------------------------------------------------------------------
module sppl_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sppl_pkg::cls_type wdata,
   input  logic              pop,
   output sppl_pkg::cls_type rdata,
   output logic              full,
   output logic              empty
);

   sppl_pkg::cls_type mem_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign rdata = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

endmodule

// ===== src/sppl_rsp_fifo.sv =====
// ---------------------------------------------------------------------------
// sppl_rsp_fifo
// two-entry output queue holding finished results
// ---------------------------------------------------------------------------
module sppl_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sppl_pkg::rsp_type wdata,
   input  logic              pop,
   output sppl_pkg::rsp_type rdata,
   output logic              full,
   output logic              empty
);

   sppl_pkg::rsp_type mem_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_pop;

   assign do_pop = pop & (cnt_ff != 2'd0);

   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ do_pop;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, do_pop};
   end

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign rdata = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

endmodule

// ===== src/sppl_engine.sv =====
// ---------------------------------------------------------------------------
// sppl_engine
// phase sequencer, timers, line matcher and configuration registers
// ---------------------------------------------------------------------------
module sppl_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [sppl_pkg::IDX_W-1:0]   csr_index,
   input  logic [sppl_pkg::CFG_W-1:0]   csr_wdata,
   input  logic                         q_empty,
   input  sppl_pkg::cls_type            q_data,
   output logic                         q_pop,
   input  logic                         r_full,
   output logic                         r_push,
   output sppl_pkg::rsp_type            r_data
);

   localparam int TW = sppl_pkg::TIMER_WIDTH;
   localparam int CW = sppl_pkg::CMP_W;
   localparam int LW = sppl_pkg::LL_W;

   // configuration
   logic [7:0]                 exc_ff;
   logic [sppl_pkg::CFG_W-1:0] rto_ff, wup_ff, pw_ff, sil_ff;

   // check state
   logic [1:0]    phase_ff, phase_in;
   logic [TW-1:0] warm_ff, warm_in;
   logic [TW-1:0] wait_ff, wait_in;
   logic [7:0]    idx_ff, idx_in;
   logic [7:0]    tally_ff, tally_in;
   logic [LW-1:0] llen_ff, llen_in;
   logic [2:0]    tlen_ff, tlen_in;
   logic          tmatch_ff, tmatch_in;
   logic          tend_ff, tend_in;

   // line matcher next values
   logic          feed_hit;
   logic [LW-1:0] feed_llen;
   logic [2:0]    feed_tlen;
   logic          feed_tmatch, feed_tend;

   logic [TW-1:0] warm_bump, wait_bump;
   logic          wait_lt_pw, wait_lt_rto;

   assign q_pop  = ~q_empty & ~r_full;
   assign r_push = q_pop;

   assign warm_bump   = (warm_ff == {TW{1'b1}}) ? warm_ff : warm_ff + 1'b1;
   assign wait_bump   = (wait_ff == {TW{1'b1}}) ? wait_ff : wait_ff + 1'b1;
   assign wait_lt_pw  = CW'(wait_ff) < CW'(pw_ff);
   assign wait_lt_rto = CW'(wait_ff) < CW'(rto_ff);

   // line matcher: cr ignored, lf ends a line, overlong lines start over
   always_comb begin
      feed_hit    = 1'b0;
      feed_llen   = llen_ff;
      feed_tlen   = tlen_ff;
      feed_tmatch = tmatch_ff;
      feed_tend   = tend_ff;
      if (q_data.is_lf) begin
         feed_hit    = tmatch_ff & (tlen_ff == 3'd4);
         feed_llen   = '0;
         feed_tlen   = 3'd0;
         feed_tmatch = 1'b1;
         feed_tend   = 1'b0;
      end else if (q_data.is_cr) begin
         feed_hit = 1'b0;
      end else if (llen_ff < LW'(sppl_pkg::LINE_CAPACITY - 1)) begin
         feed_llen = llen_ff + 1'b1;
         if (!tend_ff) begin
            if (q_data.is_nul) begin
               feed_tend = 1'b1;
            end else if (tmatch_ff && tlen_ff < 3'd4 && q_data.is_letter
                         && {1'b0, q_data.letter} == tlen_ff) begin
               feed_tlen = tlen_ff + 3'd1;
            end else begin
               feed_tmatch = 1'b0;
            end
         end
      end else begin
         feed_llen   = '0;
         feed_tlen   = 3'd0;
         feed_tmatch = 1'b1;
         feed_tend   = 1'b0;
      end
   end

   // phase sequencer
   always_comb begin
      logic       series_go;
      logic       next_go;
      logic       probe;
      logic [8:0] idx_inc;
      series_go = 1'b0;
      next_go   = 1'b0;
      probe     = 1'b0;
      idx_inc   = 9'd0;

      phase_in  = phase_ff;
      warm_in   = warm_ff;
      wait_in   = wait_ff;
      idx_in    = idx_ff;
      tally_in  = tally_ff;
      llen_in   = llen_ff;
      tlen_in   = tlen_ff;
      tmatch_in = tmatch_ff;
      tend_in   = tend_ff;
      r_data    = '0;

      case (q_data.cmd)
         sppl_pkg::CMD_START: begin
            phase_in = sppl_pkg::PH_WARMUP;
            warm_in  = '0;
            idx_in   = 8'd0;
            tally_in = 8'd0;
            if (wup_ff == '0) begin
               phase_in             = sppl_pkg::PH_IDLE;
               r_data.done_res      = 1'b1;
               r_data.warmup_failed = 1'b1;
            end else begin
               probe = 1'b1;
            end
         end
         sppl_pkg::CMD_TICK: begin
            case (phase_ff)
               sppl_pkg::PH_WARMUP: begin
                  warm_in = warm_bump;
                  wait_in = wait_bump;
                  if (CW'(wait_bump) >= CW'(pw_ff)) begin
                     if (CW'(warm_bump) >= CW'(wup_ff)) begin
                        phase_in             = sppl_pkg::PH_IDLE;
                        r_data.done_res      = 1'b1;
                        r_data.warmup_failed = 1'b1;
                     end else begin
                        probe = 1'b1;
                     end
                  end
               end
               sppl_pkg::PH_DRAIN: begin
                  wait_in = wait_bump;
                  if (CW'(wait_bump) >= CW'(sil_ff)) begin
                     series_go = 1'b1;
                  end
               end
               sppl_pkg::PH_SERIES: begin
                  wait_in = wait_bump;
                  if (CW'(wait_bump) >= CW'(rto_ff)) begin
                     next_go = 1'b1;
                  end
               end
               default: begin
                  wait_in = wait_ff;
               end
            endcase
         end
         sppl_pkg::CMD_BYTE: begin
            case (phase_ff)
               sppl_pkg::PH_WARMUP: begin
                  if (wait_lt_pw) begin
                     llen_in   = feed_llen;
                     tlen_in   = feed_tlen;
                     tmatch_in = feed_tmatch;
                     tend_in   = feed_tend;
                     if (feed_hit) begin
                        // pong seen: move on to drain with a fresh line, or to the series if silence is 0
                        phase_in  = sppl_pkg::PH_DRAIN;
                        wait_in   = '0;
                        llen_in   = '0;
                        tlen_in   = 3'd0;
                        tmatch_in = 1'b1;
                        tend_in   = 1'b0;
                        series_go = (sil_ff == '0);
                     end
                  end
               end
               sppl_pkg::PH_DRAIN: begin
                  wait_in = '0;
               end
               sppl_pkg::PH_SERIES: begin
                  if (wait_lt_rto) begin
                     llen_in   = feed_llen;
                     tlen_in   = feed_tlen;
                     tmatch_in = feed_tmatch;
                     tend_in   = feed_tend;
                     if (feed_hit) begin
                        tally_in = tally_ff + 8'd1;
                        next_go  = 1'b1;
                     end
                  end
               end
               default: begin
                  wait_in = wait_ff;
               end
            endcase
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      if (series_go) begin
         phase_in = sppl_pkg::PH_SERIES;
         idx_in   = 8'd0;
         tally_in = 8'd0;
         if (exc_ff == 8'd0) begin
            phase_in        = sppl_pkg::PH_IDLE;
            r_data.done_res = 1'b1;
            r_data.passed   = 1'b1;
         end else if (rto_ff == '0) begin
            phase_in        = sppl_pkg::PH_IDLE;
            r_data.done_res = 1'b1;
         end else begin
            probe = 1'b1;
         end
      end

      if (next_go) begin
         idx_inc = {1'b0, idx_ff} + 9'd1;
         idx_in  = idx_inc[7:0];
         if (idx_inc >= {1'b0, exc_ff}) begin
            phase_in        = sppl_pkg::PH_IDLE;
            r_data.done_res = 1'b1;
            r_data.passed   = (tally_in == exc_ff);
         end else begin
            probe = 1'b1;
         end
      end

      if (probe) begin
         r_data.send_ping = 1'b1;
         wait_in          = '0;
         llen_in          = '0;
         tlen_in          = 3'd0;
         tmatch_in        = 1'b1;
         tend_in          = 1'b0;
      end

      r_data.pong_count = tally_in;
      r_data.busy_res   = (phase_in != sppl_pkg::PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exc_ff <= 8'd10;
         rto_ff <= 16'd200;
         wup_ff <= 16'd5000;
         pw_ff  <= 16'd500;
         sil_ff <= 16'd50;
      end else if (csr_we) begin
         case (csr_index)
            sppl_pkg::REG_EXCHANGE_COUNT: exc_ff <= csr_wdata[7:0];
            sppl_pkg::REG_REPLY_TIMEOUT:  rto_ff <= csr_wdata;
            sppl_pkg::REG_WARMUP:         wup_ff <= csr_wdata;
            sppl_pkg::REG_PROBE_WAIT:     pw_ff  <= csr_wdata;
            sppl_pkg::REG_SILENCE:        sil_ff <= csr_wdata;
            default:                      exc_ff <= exc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= sppl_pkg::PH_IDLE;
         warm_ff   <= '0;
         wait_ff   <= '0;
         idx_ff    <= 8'd0;
         tally_ff  <= 8'd0;
         llen_ff   <= '0;
         tlen_ff   <= 3'd0;
         tmatch_ff <= 1'b1;
         tend_ff   <= 1'b0;
      end else if (q_pop) begin
         phase_ff  <= phase_in;
         warm_ff   <= warm_in;
         wait_ff   <= wait_in;
         idx_ff    <= idx_in;
         tally_ff  <= tally_in;
         llen_ff   <= llen_in;
         tlen_ff   <= tlen_in;
         tmatch_ff <= tmatch_in;
         tend_ff   <= tend_in;
      end
   end

endmodule

// ===== src/serial_ping_pong_link_checker.sv =====
// ---------------------------------------------------------------------------
// serial_ping_pong_link_checker
// link check over a serial line: warmup probes, drain, strict ping series
// ---------------------------------------------------------------------------
// an accepted request is registered in the request queue, then in the result queue
// throughput: one request per cycle while the result queue has room, one engine update per request
// full rises only when both the request queue and result queue are backed up
// reset: synchronous, clears queues, phase to idle and registers to defaults
// ---------------------------------------------------------------------------
module serial_ping_pong_link_checker (
   input  logic                       clock,
   input  logic                       reset,
   // request side
   input  logic                       push,
   output logic                       full,
   input  logic [1:0]                 req_command,
   input  logic [7:0]                 req_rx_byte,
   // result side
   output logic                       empty,
   input  logic                       pop,
   output logic                       rsp_send_ping,
   output logic                       rsp_done_res,
   output logic                       rsp_passed,
   output logic                       rsp_warmup_failed,
   output logic [7:0]                 rsp_pong_count,
   output logic                       rsp_busy_res,
   // register writes
   input  logic                       csr_we,
   input  logic [sppl_pkg::IDX_W-1:0] csr_index,
   input  logic [sppl_pkg::CFG_W-1:0] csr_wdata
);

   // classified requests waiting for the engine
   sppl_pkg::cls_type cls_wdata, cls_rdata;
   logic              cls_push, cls_pop, cls_empty;

   // finished results waiting for the consumer
   sppl_pkg::rsp_type res_wdata, res_rdata;
   logic              res_push, res_full;

   // front: decode the request and tag special characters
   sppl_front u_front (
      .push    (push),
      .full    (full),
      .command (req_command),
      .rx_byte (req_rx_byte),
      .q_push  (cls_push),
      .q_data  (cls_wdata)
   );

   // decoupling queue lets front keep accepting while the engine stalls
   sppl_cmd_fifo u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cls_push),
      .wdata (cls_wdata),
      .pop   (cls_pop),
      .rdata (cls_rdata),
      .full  (full),
      .empty (cls_empty)
   );

   // back: one state update per request, runs when a result slot is free
   sppl_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_empty   (cls_empty),
      .q_data    (cls_rdata),
      .q_pop     (cls_pop),
      .r_full    (res_full),
      .r_push    (res_push),
      .r_data    (res_wdata)
   );

   // output queue parts the engine from the consumer
   sppl_rsp_fifo u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (res_wdata),
      .pop   (pop),
      .rdata (res_rdata),
      .full  (res_full),
      .empty (empty)
   );

   // oldest result on the ports
   assign rsp_send_ping     = res_rdata.send_ping;
   assign rsp_done_res      = res_rdata.done_res;
   assign rsp_passed        = res_rdata.passed;
   assign rsp_warmup_failed = res_rdata.warmup_failed;
   assign rsp_pong_count    = res_rdata.pong_count;
   assign rsp_busy_res      = res_rdata.busy_res;

endmodule

// ===== src/sppl_checker.sv =====
// ---------------------------------------------------------------------------
// sppl_checker
// port-level checks of the link checker, bound to the top level
// ---------------------------------------------------------------------------
module sppl_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       rsp_done_res,
   input logic       rsp_passed,
   input logic       rsp_warmup_failed,
   input logic       rsp_busy_res
);

   // queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_reset_room: assert property (@(posedge clock) reset |=> !full)
      else $error("request queue full after reset");

   // verdict bits only come with a finishing result
   a_verdict_done: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_passed || rsp_warmup_failed)) |-> rsp_done_res)
      else $error("verdict without done");

   // a finishing result leaves the block idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_done_res) |-> !rsp_busy_res)
      else $error("busy after done");

   // a check cannot both pass and fail warmup
   a_verdict_excl: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_passed && rsp_warmup_failed))
      else $error("passed and warmup failed together");

endmodule

bind serial_ping_pong_link_checker sppl_checker u_sppl_checker (
   .clock             (clock),
   .reset             (reset),
   .full              (full),
   .empty             (empty),
   .rsp_done_res      (rsp_done_res),
   .rsp_passed        (rsp_passed),
   .rsp_warmup_failed (rsp_warmup_failed),
   .rsp_busy_res      (rsp_busy_res)
);

// ===== bench/link_status_monitor.sv =====
// ---------------------------------------------------------------------------
// link_status_monitor
// watches the request, result and register ports of the ping-pong link
// checker, predicts each status word and compares it in order
// ---------------------------------------------------------------------------
module link_status_monitor (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic                       full,
   input  logic [1:0]                 req_command,
   input  logic [7:0]                 req_rx_byte,
   input  logic                       empty,
   input  logic                       pop,
   input  logic                       rsp_send_ping,
   input  logic                       rsp_done_res,
   input  logic                       rsp_passed,
   input  logic                       rsp_warmup_failed,
   input  logic [7:0]                 rsp_pong_count,
   input  logic                       rsp_busy_res,
   input  logic                       csr_we,
   input  logic [sppl_pkg::IDX_W-1:0] csr_index,
   input  logic [sppl_pkg::CFG_W-1:0] csr_wdata,
   output int                         mismatch_total,
   output int                         outstanding,
   output int                         sent_requests
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0]  DEF_EXCHANGES  = 8'd10;
   localparam logic [15:0] DEF_REPLY_MS   = 16'd200;
   localparam logic [15:0] DEF_WARMUP_MS  = 16'd5000;
   localparam logic [15:0] DEF_PROBE_MS   = 16'd500;
   localparam logic [15:0] DEF_SILENCE_MS = 16'd50;
   localparam int          FILL_LIMIT     = sppl_pkg::LINE_CAPACITY - 1;
   localparam logic [31:0] PONG_WORD      = {sppl_pkg::CH_P, sppl_pkg::CH_O,
                                             sppl_pkg::CH_N, sppl_pkg::CH_G};

   // register copies
   logic [7:0]  cfg_exchanges;
   logic [15:0] cfg_reply_ms, cfg_warmup_ms, cfg_probe_ms, cfg_silence_ms;

   // predicted link state
   logic [1:0]                       phase_q;
   logic [sppl_pkg::TIMER_WIDTH-1:0] warm_ticks, window_ticks;
   logic [7:0]                       probe_idx, pong_tally;
   int                               line_fill, text_len;
   bit                               text_ok, text_stop;

   sppl_pkg::rsp_type next_status;
   sppl_pkg::rsp_type status_due[$];
   sppl_pkg::rsp_type seen, want;

   function automatic logic [sppl_pkg::TIMER_WIDTH-1:0] sat_inc(
      input logic [sppl_pkg::TIMER_WIDTH-1:0] t);
      return (t == '1) ? t : t + 1'b1;
   endfunction

   function automatic void clear_line();
      line_fill = 0;
      text_len  = 0;
      text_ok   = 1'b1;
      text_stop = 1'b0;
   endfunction

   // one byte into the line matcher, 1 when a PONG line completes
   function automatic bit line_closes_pong(input logic [7:0] ch);
      bit hit;
      hit = 1'b0;
      if (ch == sppl_pkg::CH_LF) begin
         hit = text_ok && (text_len == 4);
         clear_line();
      end else if (ch != sppl_pkg::CH_CR) begin
         if (line_fill < FILL_LIMIT) begin
            line_fill++;
            if (!text_stop) begin
               if (ch == sppl_pkg::CH_NUL)
                  text_stop = 1'b1;
               else if (text_ok && text_len < 4 && ch == PONG_WORD[8*(3-text_len) +: 8])
                  text_len++;
               else
                  text_ok = 1'b0;
            end
         end else begin
            clear_line();
         end
      end
      return hit;
   endfunction

   function automatic void open_probe();
      next_status.send_ping = 1'b1;
      window_ticks = '0;
      clear_line();
   endfunction

   function automatic void conclude(input bit ok, input bit warm_fail);
      phase_q = sppl_pkg::PH_IDLE;
      next_status.done_res      = 1'b1;
      next_status.passed        = ok;
      next_status.warmup_failed = warm_fail;
   endfunction

   function automatic void begin_series();
      phase_q    = sppl_pkg::PH_SERIES;
      probe_idx  = '0;
      pong_tally = '0;
      if (cfg_exchanges == '0)
         conclude(1'b1, 1'b0);
      else if (cfg_reply_ms == '0)
         conclude(1'b0, 1'b0);
      else
         open_probe();
   endfunction

   function automatic void next_exchange();
      probe_idx++;
      if (probe_idx >= cfg_exchanges)
         conclude(pong_tally == cfg_exchanges, 1'b0);
      else
         open_probe();
   endfunction

   // status word caused by one request
   function automatic sppl_pkg::rsp_type advance_link(input logic [1:0] cmd,
                                                       input logic [7:0] rx);
      next_status = '0;
      case (cmd)
         sppl_pkg::CMD_START: begin
            phase_q    = sppl_pkg::PH_WARMUP;
            warm_ticks = '0;
            probe_idx  = '0;
            pong_tally = '0;
            if (cfg_warmup_ms == '0)
               conclude(1'b0, 1'b1);
            else
               open_probe();
         end
         sppl_pkg::CMD_TICK: begin
            case (phase_q)
               sppl_pkg::PH_WARMUP: begin
                  warm_ticks   = sat_inc(warm_ticks);
                  window_ticks = sat_inc(window_ticks);
                  if (window_ticks >= cfg_probe_ms) begin
                     if (warm_ticks >= cfg_warmup_ms)
                        conclude(1'b0, 1'b1);
                     else
                        open_probe();
                  end
               end
               sppl_pkg::PH_DRAIN: begin
                  window_ticks = sat_inc(window_ticks);
                  if (window_ticks >= cfg_silence_ms)
                     begin_series();
               end
               sppl_pkg::PH_SERIES: begin
                  window_ticks = sat_inc(window_ticks);
                  if (window_ticks >= cfg_reply_ms)
                     next_exchange();
               end
               default: ;
            endcase
         end
         sppl_pkg::CMD_BYTE: begin
            case (phase_q)
               sppl_pkg::PH_WARMUP: begin
                  if (window_ticks < cfg_probe_ms) begin
                     if (line_closes_pong(rx)) begin
                        phase_q      = sppl_pkg::PH_DRAIN;
                        window_ticks = '0;
                        clear_line();
                        if (cfg_silence_ms == '0)
                           begin_series();
                     end
                  end
               end
               sppl_pkg::PH_DRAIN: window_ticks = '0;
               sppl_pkg::PH_SERIES: begin
                  if (window_ticks < cfg_reply_ms) begin
                     if (line_closes_pong(rx)) begin
                        pong_tally++;
                        next_exchange();
                     end
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      next_status.pong_count = pong_tally;
      next_status.busy_res   = (phase_q != sppl_pkg::PH_IDLE);
      return next_status;
   endfunction

   function automatic string status_text(input sppl_pkg::rsp_type s);
      return $sformatf("ping %0b done %0b pass %0b wfail %0b pongs %0d busy %0b",
                       s.send_ping, s.done_res, s.passed, s.warmup_failed,
                       s.pong_count, s.busy_res);
   endfunction

   task automatic note_fault(input string text);
      mismatch_total++;
      if (mismatch_total <= 10)
         $display("[%0t] %s", $time, text);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_exchanges  = DEF_EXCHANGES;
         cfg_reply_ms   = DEF_REPLY_MS;
         cfg_warmup_ms  = DEF_WARMUP_MS;
         cfg_probe_ms   = DEF_PROBE_MS;
         cfg_silence_ms = DEF_SILENCE_MS;
         phase_q        = sppl_pkg::PH_IDLE;
         warm_ticks     = '0;
         window_ticks   = '0;
         probe_idx      = '0;
         pong_tally     = '0;
         clear_line();
         status_due.delete();
         mismatch_total = 0;
         sent_requests  = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               sppl_pkg::REG_EXCHANGE_COUNT: cfg_exchanges  = csr_wdata[7:0];
               sppl_pkg::REG_REPLY_TIMEOUT:  cfg_reply_ms   = csr_wdata;
               sppl_pkg::REG_WARMUP:         cfg_warmup_ms  = csr_wdata;
               sppl_pkg::REG_PROBE_WAIT:     cfg_probe_ms   = csr_wdata;
               sppl_pkg::REG_SILENCE:        cfg_silence_ms = csr_wdata;
               default: ;
            endcase
         end
         if (pop && !empty) begin
            seen.send_ping     = rsp_send_ping;
            seen.done_res      = rsp_done_res;
            seen.passed        = rsp_passed;
            seen.warmup_failed = rsp_warmup_failed;
            seen.pong_count    = rsp_pong_count;
            seen.busy_res      = rsp_busy_res;
            if (status_due.size() == 0) begin
               note_fault("status popped with no request waiting on it");
            end else begin
               want = status_due.pop_front();
               if (seen !== want)
                  note_fault($sformatf("status mismatch: want %s, got %s",
                                       status_text(want), status_text(seen)));
            end
         end
         if (push && !full) begin
            sent_requests++;
            status_due.push_back(advance_link(req_command, req_rx_byte));
         end
      end
      outstanding = status_due.size();
   end

endmodule

// ===== bench/tb_serial_ping_pong_link_checker.sv =====
// ---------------------------------------------------------------------------
// tb_serial_ping_pong_link_checker
// drives start, tick, byte and spare requests into the link checker with random
// gaps and result back-pressure; a status monitor beside the block predicts
// and compares every status word, this module makes stimulus and the verdict
// ---------------------------------------------------------------------------
module tb_serial_ping_pong_link_checker;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [sppl_pkg::CFG_W-1:0] cfg_word_type;

   // the one command code the block must ignore
   localparam logic [1:0] CMD_SPARE   = 2'd3;
   // requests to accept before the random sessions stop
   localparam int         ITEM_TARGET = 850;
   // worst case is about a thousand requests, each behind a long gap and stall
   localparam int         CYCLE_LIMIT = 1000000;
   localparam int         LONG_SERIES = 255;

   logic                         clock;
   logic                         reset       = 1'b1;
   logic                         push        = 1'b0;
   logic                         full;
   logic [1:0]                   req_command = sppl_pkg::CMD_START;
   logic [7:0]                   req_rx_byte = '0;
   logic                         empty;
   logic                         pop         = 1'b0;
   logic                         rsp_send_ping, rsp_done_res, rsp_passed, rsp_warmup_failed;
   logic [7:0]                   rsp_pong_count;
   logic                         rsp_busy_res;
   logic                         csr_we      = 1'b0;
   logic [sppl_pkg::IDX_W-1:0]   csr_index   = '0;
   cfg_word_type                 csr_wdata   = '0;

   int                  mismatch_total, outstanding, sent_requests;
   int                  cycle_count = 0;
   bit                  req_calm    = 1'b0;

   serial_ping_pong_link_checker uut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_command       (req_command),
      .req_rx_byte       (req_rx_byte),
      .empty             (empty),
      .pop               (pop),
      .rsp_send_ping     (rsp_send_ping),
      .rsp_done_res      (rsp_done_res),
      .rsp_passed        (rsp_passed),
      .rsp_warmup_failed (rsp_warmup_failed),
      .rsp_pong_count    (rsp_pong_count),
      .rsp_busy_res      (rsp_busy_res),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   link_status_monitor monitor (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_command       (req_command),
      .req_rx_byte       (req_rx_byte),
      .empty             (empty),
      .pop               (pop),
      .rsp_send_ping     (rsp_send_ping),
      .rsp_done_res      (rsp_done_res),
      .rsp_passed        (rsp_passed),
      .rsp_warmup_failed (rsp_warmup_failed),
      .rsp_pong_count    (rsp_pong_count),
      .rsp_busy_res      (rsp_busy_res),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_total    (mismatch_total),
      .outstanding       (outstanding),
      .sent_requests     (sent_requests)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // hard stop in case the block hangs
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_serial_ping_pong_link_checker: errors");
      $finish;
   end

   // result side: random pops, some long stalls, and calm stretches with none
   initial begin : result_drain
      int stall, span, roll;
      bit calm;
      stall = 0;
      span  = 0;
      calm  = 1'b0;
      forever begin
         @(negedge clock);
         if (span == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            span = $urandom_range(100, 400);
         end
         span--;
         roll = $urandom_range(0, 99);
         if (stall > 0) begin
            pop = 1'b0;
            stall--;
         end else if (calm) begin
            pop = 1'b1;
         end else if (roll < 3) begin
            pop   = 1'b0;
            stall = $urandom_range(10, 40);
         end else begin
            pop = (roll >= 30);
         end
      end
   end

   // one request; push stays high into the next request when no gap is drawn
   task automatic send_req(input logic [1:0] cmd, input logic [7:0] data);
      int roll;
      @(negedge clock);
      push        = 1'b1;
      req_command = cmd;
      req_rx_byte = data;
      @(posedge clock);
      while (full) @(posedge clock);
      roll = $urandom_range(0, 99);
      if (!req_calm && roll < 30) begin
         @(negedge clock);
         push = 1'b0;
         repeat ((roll < 3) ? $urandom_range(10, 40) : $urandom_range(0, 2)) @(negedge clock);
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_req(sppl_pkg::CMD_BYTE, s[i]);
   endtask

   // a random byte for fields the block does not look at
   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // a PONG line, CR placed in a few spots the matcher must skip
   task automatic send_pong_reply();
      case ($urandom_range(0, 3))
         0:       send_text("PONG\n");
         1:       send_text("PONG\r\n");
         2:       send_text("\rPONG\n");
         default: send_text("PO\rNG\n");
      endcase
   endtask

   // stop sending and wait until every status word has been popped
   task automatic settle();
      @(negedge clock);
      push = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [sppl_pkg::IDX_W-1:0] idx, input cfg_word_type value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // mostly small so checks finish quickly, sometimes zero or full scale
   function automatic cfg_word_type pick_setting(input cfg_word_type top_value,
                                                 input int span_max);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         return '0;
      if (roll < 18)
         return top_value;
      return cfg_word_type'($urandom_range(1, span_max));
   endfunction

   initial begin : stimulus
      int    steps, roll, keep, extra;
      string pong;
      pong = "PONG";

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed part ----

      // requests while idle are ignored, including the spare command
      send_req(sppl_pkg::CMD_BYTE, 8'hFF);
      send_req(sppl_pkg::CMD_TICK, 8'h00);
      send_req(CMD_SPARE, 8'hA5);
      send_req(sppl_pkg::CMD_BYTE, sppl_pkg::CH_NUL);
      settle();

      // zero warmup budget: start fails at once
      write_reg(sppl_pkg::REG_WARMUP, '0);
      send_req(sppl_pkg::CMD_START, 8'h00);
      settle();

      // zero probe wait: bytes ignored, a ping per tick until the budget runs out;
      // second start restarts the busy check
      write_reg(sppl_pkg::REG_WARMUP, 16'd3);
      write_reg(sppl_pkg::REG_PROBE_WAIT, '0);
      send_req(sppl_pkg::CMD_START, 8'h00);
      send_req(sppl_pkg::CMD_START, 8'hFF);
      send_req(sppl_pkg::CMD_BYTE, sppl_pkg::CH_LF);
      repeat (3) send_req(sppl_pkg::CMD_TICK, 8'h00);
      settle();

      // zero silence and zero exchange count: the PONG line ends the check, passed
      write_reg(sppl_pkg::REG_PROBE_WAIT, 16'd2);
      write_reg(sppl_pkg::REG_WARMUP, 16'd10);
      write_reg(sppl_pkg::REG_SILENCE, '0);
      write_reg(sppl_pkg::REG_EXCHANGE_COUNT, '0);
      send_req(sppl_pkg::CMD_START, 8'h00);
      send_text("PONG\n");
      settle();

      // zero reply timeout with one exchange: the series fails at once, no ping
      write_reg(sppl_pkg::REG_EXCHANGE_COUNT, 16'd1);
      write_reg(sppl_pkg::REG_REPLY_TIMEOUT, '0);
      send_req(sppl_pkg::CMD_START, 8'h00);
      send_text("PONG\r\n");
      settle();

      // ---- long series ----
      // every tick times a probe out, so the full count of exchanges runs quickly
      // and pong_count climbs well into its upper bits
      write_reg(sppl_pkg::REG_EXCHANGE_COUNT, cfg_word_type'(LONG_SERIES));
      write_reg(sppl_pkg::REG_REPLY_TIMEOUT, 16'd1);
      write_reg(sppl_pkg::REG_WARMUP, 16'd50);
      write_reg(sppl_pkg::REG_PROBE_WAIT, 16'd3);
      write_reg(sppl_pkg::REG_SILENCE, 16'd1);
      send_req(sppl_pkg::CMD_START, any_byte());
      send_req(sppl_pkg::CMD_TICK, any_byte());
      send_pong_reply();
      send_req(sppl_pkg::CMD_TICK, any_byte());
      repeat (LONG_SERIES) begin
         if ($urandom_range(0, 99) < 40)
            send_text("PONG\n");
         else
            send_req(sppl_pkg::CMD_TICK, any_byte());
      end
      settle();

      // ---- random sessions ----
      while (sent_requests < ITEM_TARGET) begin
         // registers change only once every status word is back
         settle();
         if ($urandom_range(0, 3) != 0)
            write_reg(sppl_pkg::REG_EXCHANGE_COUNT, pick_setting(16'd255, 6));
         if ($urandom_range(0, 3) != 0)
            write_reg(sppl_pkg::REG_REPLY_TIMEOUT, pick_setting(16'hFFFF, 6));
         if ($urandom_range(0, 3) != 0)
            write_reg(sppl_pkg::REG_WARMUP, pick_setting(16'hFFFF, 40));
         if ($urandom_range(0, 3) != 0)
            write_reg(sppl_pkg::REG_PROBE_WAIT, pick_setting(16'hFFFF, 8));
         if ($urandom_range(0, 3) != 0)
            write_reg(sppl_pkg::REG_SILENCE, pick_setting(16'hFFFF, 4));
         req_calm = ($urandom_range(0, 3) == 0);

         send_req(sppl_pkg::CMD_START, any_byte());
         steps = $urandom_range(15, 40);
         repeat (steps) begin
            roll = $urandom_range(0, 99);
            if (roll < 32) begin
               send_pong_reply();
            end else if (roll < 64) begin
               repeat ($urandom_range(1, 3)) send_req(sppl_pkg::CMD_TICK, any_byte());
            end else if (roll < 74) begin
               // near miss: a PONG prefix, maybe with extra letters
               keep  = $urandom_range(0, 4);
               extra = $urandom_range(0, 2);
               if (keep == 4 && extra == 0)
                  extra = 1;
               for (int i = 0; i < keep; i++)
                  send_req(sppl_pkg::CMD_BYTE, pong[i]);
               repeat (extra) send_req(sppl_pkg::CMD_BYTE, pong[$urandom_range(0, 3)]);
               send_req(sppl_pkg::CMD_BYTE, sppl_pkg::CH_LF);
            end else if (roll < 79) begin
               // zero byte ends the compared text: trailing junk is fine, leading is not
               if ($urandom_range(0, 1)) begin
                  send_text("PONG");
                  send_req(sppl_pkg::CMD_BYTE, sppl_pkg::CH_NUL);
                  repeat ($urandom_range(0, 3)) send_req(sppl_pkg::CMD_BYTE, any_byte());
               end else begin
                  send_req(sppl_pkg::CMD_BYTE, sppl_pkg::CH_NUL);
                  send_text("PONG");
               end
               send_req(sppl_pkg::CMD_BYTE, sppl_pkg::CH_LF);
            end else if (roll < 84) begin
               // overlong line: the overflow restart lands around the PONG
               repeat ($urandom_range(14, 17))
                  send_req(sppl_pkg::CMD_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
               send_text("PONG\n");
            end else if (roll < 92) begin
               send_req(sppl_pkg::CMD_BYTE, any_byte());
            end else if (roll < 95) begin
               send_req(CMD_SPARE, any_byte());
            end else if (roll < 98) begin
               send_req(sppl_pkg::CMD_START, any_byte());
            end else begin
               // sender holds off mid-check until every status word is back
               settle();
            end
         end
      end

      settle();
      if (mismatch_total == 0 && outstanding == 0)
         $display("tb_serial_ping_pong_link_checker: clean");
      else
         $display("tb_serial_ping_pong_link_checker: errors");
      $finish;
   end

endmodule
